>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified assertion shorthands for the compensation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst_n is low.
`define PSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define PSC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pressure sensor compensation block.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned RAW_P_W    = 20;
  localparam int unsigned RAW_T_W    = 20;
  localparam int unsigned RAW_H_W    = 16;
  localparam int unsigned HUM_W      = 17;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned SIDE_W     = 32 + HUM_W + 1;

  localparam int unsigned PRESS_FINE_OFS = 128000;
  localparam int unsigned P_BASE         = 1048576;
  localparam int unsigned P_SCALE        = 3125;
  localparam int unsigned HUM_FINE_OFS   = 76800;
  localparam int unsigned HUM_MAX        = 419430400;
  localparam int unsigned HUM_ADD        = 2097152;
  localparam int unsigned HUM_RND        = 16384;
  localparam int unsigned HUM_K          = 32768;
  localparam int unsigned HUM_RND2       = 8192;
  localparam int unsigned HUM_OUT_MAX    = 102400;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_LO = 3'd1,
    CFG_PRESS_HI = 3'd2,
    CFG_MIXED    = 3'd3,
    CFG_HUM      = 3'd4,
    CFG_HAS_HUM  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               has_hum;
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } coeff_t;

endpackage

>>> rtl/pressure_sensor_compensation.sv
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Integer compensation of raw pressure, temperature and humidity counts.
// ----------------------------------------------------------------------------
// Takes one raw sample beat per clock and returns one compensated beat per
// sample, in order: 4 temperature stages, 6 stages that build the pressure
// dividend and divisor (humidity runs beside them), the 64-stage restoring
// divider that sets the latency, and 5 pressure output stages ending in the
// output register. Throughput is one beat per cycle unless stalled. The
// whole pipeline advances together; it holds only while a result sits in
// the output register and is not taken. Calibration words go in through
// cfg_we/cfg_addr/cfg_wdata and must be written while no sample is in
// flight. A zero pressure divisor gives pressure 0 with out_tuser set.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation import psc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // temperature[31:0], pressure[63:32], humidity[80:64], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // pressure_invalid[0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  // calibration registers
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [47:0] mixed_r;
  logic [31:0] hum_coeffs_r;
  logic        has_hum_r;
  coeff_t      coeff;

  logic en;

  logic               t_valid;
  logic [31:0]        t_fine, t_temp;
  logic [RAW_P_W-1:0] t_raw_p;
  logic [RAW_H_W-1:0] t_raw_h;

  logic               f_valid, f_neg, f_inv;
  logic [DIV_W-1:0]   f_ma, f_mb;
  logic [31:0]        f_temp;
  logic [HUM_W-1:0]   h_hum;

  logic               d_valid, d_neg;
  logic [DIV_W-1:0]   d_quo;
  logic [SIDE_W-1:0]  d_side;

  logic [31:0]        o_temp, o_press;
  logic               o_inv;
  logic [HUM_W-1:0]   o_hum;

  // write one calibration register; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_lo_r    <= '0;
      press_hi_r    <= '0;
      mixed_r       <= '0;
      hum_coeffs_r  <= '0;
      has_hum_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_TEMP:     temp_coeffs_r <= cfg_wdata[47:0];
        CFG_PRESS_LO: press_lo_r    <= cfg_wdata;
        CFG_PRESS_HI: press_hi_r    <= cfg_wdata;
        CFG_MIXED:    mixed_r       <= cfg_wdata[47:0];
        CFG_HUM:      hum_coeffs_r  <= cfg_wdata[31:0];
        CFG_HAS_HUM:  has_hum_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // unpack the calibration words into named coefficients
  always_comb begin
    coeff.has_hum = has_hum_r;
    coeff.t1 = temp_coeffs_r[15:0];
    coeff.t2 = temp_coeffs_r[31:16];
    coeff.t3 = temp_coeffs_r[47:32];
    coeff.p1 = press_lo_r[15:0];
    coeff.p2 = press_lo_r[31:16];
    coeff.p3 = press_lo_r[47:32];
    coeff.p4 = press_lo_r[63:48];
    coeff.p5 = press_hi_r[15:0];
    coeff.p6 = press_hi_r[31:16];
    coeff.p7 = press_hi_r[47:32];
    coeff.p8 = press_hi_r[63:48];
    coeff.p9 = mixed_r[15:0];
    coeff.h1 = mixed_r[23:16];
    coeff.h2 = mixed_r[39:24];
    coeff.h3 = mixed_r[47:40];
    coeff.h4 = hum_coeffs_r[11:0];
    coeff.h5 = hum_coeffs_r[23:12];
    coeff.h6 = hum_coeffs_r[31:24];
  end

  // advance every stage unless a finished beat is waiting to be taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  psc_temp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .raw_p    (in_tdata[19:0]),
    .raw_t    (in_tdata[39:20]),
    .raw_h    (in_tdata[55:40]),
    .coeff    (coeff),
    .valid    (t_valid),
    .fine     (t_fine),
    .temp     (t_temp),
    .raw_p_o  (t_raw_p),
    .raw_h_o  (t_raw_h)
  );

  psc_pfront u_pfront (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (t_valid),
    .fine     (t_fine),
    .raw_p    (t_raw_p),
    .temp_i   (t_temp),
    .coeff    (coeff),
    .valid    (f_valid),
    .ma       (f_ma),
    .mb       (f_mb),
    .neg      (f_neg),
    .invalid  (f_inv),
    .temp_o   (f_temp)
  );

  // same depth as the pressure front end, so results line up
  psc_hum u_hum (
    .clk   (clk),
    .en    (en),
    .fine  (t_fine),
    .raw_h (t_raw_h),
    .coeff (coeff),
    .hum   (h_hum)
  );

  psc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .ma       (f_ma),
    .mb       (f_mb),
    .neg_i    (f_neg),
    .side_i   ({f_inv, h_hum, f_temp}),
    .valid    (d_valid),
    .quo      (d_quo),
    .neg_o    (d_neg),
    .side_o   (d_side)
  );

  psc_pback u_pback (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (d_valid),
    .quo              (d_quo),
    .neg              (d_neg),
    .side_i           (d_side),
    .coeff            (coeff),
    .valid            (out_tvalid),
    .temperature      (o_temp),
    .pressure         (o_press),
    .pressure_invalid (o_inv),
    .humidity         (o_hum)
  );

  assign out_tdata = {(OUT_DATA_W - 64 - HUM_W)'(0), o_hum, o_press, o_temp};
  assign out_tuser = o_inv;

  `PSC_ASSERT_IMPLY(a_inv_zero, out_tvalid && out_tuser, out_tdata[63:32] == 32'd0, "invalid pressure not zero")
  `PSC_ASSERT_IMPLY(a_hum_range, out_tvalid, out_tdata[80:64] <= 17'(HUM_OUT_MAX), "humidity out of range")
  `PSC_ASSERT_IMPLY(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")

endmodule

>>> rtl/psc_temp.sv
// ----------------------------------------------------------------------------
// psc_temp
// Four-stage temperature pipeline: fine-temperature term and output value.
// ----------------------------------------------------------------------------
module psc_temp import psc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [RAW_P_W-1:0] raw_p,
  input  logic [RAW_T_W-1:0] raw_t,
  input  logic [RAW_H_W-1:0] raw_h,
  input  coeff_t             coeff,
  output logic               valid,
  output logic [31:0]        fine,
  output logic [31:0]        temp,
  output logic [RAW_P_W-1:0] raw_p_o,
  output logic [RAW_H_W-1:0] raw_h_o
);

  logic               v_r [0:3];
  logic [RAW_P_W-1:0] rp_r [0:3];
  logic [RAW_H_W-1:0] rh_r [0:3];
  logic [31:0] pa_r, pb_r, v1_r, m_r, fine3_r, fine4_r, temp_r;
  logic [31:0] a, b, t2x, t3x, bb, t5;
  logic [31:0] pa_nxt, pb_nxt, v1_nxt, m_nxt, fine_nxt, temp_nxt;

  assign t2x = 32'($signed(coeff.t2));
  assign t3x = 32'($signed(coeff.t3));
  assign a   = 32'(raw_t >> 3) - 32'({coeff.t1, 1'b0});
  assign b   = 32'(raw_t >> 4) - 32'(coeff.t1);
  assign pa_nxt = a * t2x;
  assign pb_nxt = b * b;

  assign v1_nxt = 32'($signed(pa_r) >>> 11);
  assign bb     = 32'($signed(pb_r) >>> 12);
  assign m_nxt  = bb * t3x;

  assign fine_nxt = v1_r + 32'($signed(m_r) >>> 14);

  assign t5       = fine3_r * 32'd5 + 32'd128;
  assign temp_nxt = 32'($signed(t5) >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < 4; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rp_r[0] <= raw_p;
      rh_r[0] <= raw_h;
      for (int i = 1; i < 4; i++) begin
        rp_r[i] <= rp_r[i-1];
        rh_r[i] <= rh_r[i-1];
      end
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      v1_r    <= v1_nxt;
      m_r     <= m_nxt;
      fine3_r <= fine_nxt;
      fine4_r <= fine3_r;
      temp_r  <= temp_nxt;
    end
  end

  assign valid   = v_r[3];
  assign fine    = fine4_r;
  assign temp    = temp_r;
  assign raw_p_o = rp_r[3];
  assign raw_h_o = rh_r[3];

endmodule

>>> rtl/psc_pfront.sv
// ----------------------------------------------------------------------------
// psc_pfront
// Six-stage pressure front end: builds the dividend and divisor magnitudes.
// ----------------------------------------------------------------------------
module psc_pfront import psc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        fine,
  input  logic [RAW_P_W-1:0] raw_p,
  input  logic [31:0]        temp_i,
  input  coeff_t             coeff,
  output logic               valid,
  output logic [DIV_W-1:0]   ma,
  output logic [DIV_W-1:0]   mb,
  output logic               neg,
  output logic               invalid,
  output logic [31:0]        temp_o
);

  logic               v_r  [0:5];
  logic [31:0]        tp_r [0:5];
  logic [RAW_P_W-1:0] rp_r [0:2];

  logic signed [32:0] w1s;
  logic signed [65:0] sq_full;
  logic signed [48:0] w1p5_full, w1p2_full;
  logic signed [79:0] t6_full, t3_full;
  logic        [79:0] prod_full;
  logic        [75:0] num_full;
  logic        [63:0] s, w2_nxt, w1b_nxt, n0_nxt, d_nxt;
  logic        [20:0] pp;

  logic        [63:0] sq_r, t6_r, t3_r, w2_r, w1b_r, prod_r, n0_r, d_r, num_r;
  logic signed [48:0] w1p5_r, w1p2_r, w1p5b_r, w1p2b_r;
  logic        [63:0] ma_r, mb_r;
  logic               neg_r, inv_r;

  // stage 1: offset fine temperature, squares and linear terms
  assign w1s       = $signed({fine[31], fine}) - $signed(33'(PRESS_FINE_OFS));
  assign sq_full   = w1s * w1s;
  assign w1p5_full = w1s * $signed(coeff.p5);
  assign w1p2_full = w1s * $signed(coeff.p2);

  // stage 2: quadratic coefficients
  assign t6_full = $signed(sq_r) * $signed(coeff.p6);
  assign t3_full = $signed(sq_r) * $signed(coeff.p3);

  // stage 3: collect both partial sums
  assign w2_nxt  = t6_r + (64'(w1p5b_r) << 17) + (64'($signed(coeff.p4)) << 35);
  assign w1b_nxt = 64'($signed(t3_r) >>> 8) + (64'(w1p2b_r) << 12);

  // stage 4: divisor scaling and dividend base
  assign s         = w1b_r + (64'd1 << 47);
  assign prod_full = s * coeff.p1;
  assign pp        = 21'(P_BASE) - 21'(rp_r[2]);
  assign n0_nxt    = (64'(pp) << 31) - w2_r;

  // stage 5: final divisor and scaled dividend
  assign d_nxt    = 64'($signed(prod_r) >>> 33);
  assign num_full = n0_r * 12'(P_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < 6; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r[0] <= temp_i;
      for (int i = 1; i < 6; i++) tp_r[i] <= tp_r[i-1];
      rp_r[0] <= raw_p;
      rp_r[1] <= rp_r[0];
      rp_r[2] <= rp_r[1];
      sq_r    <= sq_full[63:0];
      w1p5_r  <= w1p5_full;
      w1p2_r  <= w1p2_full;
      t6_r    <= t6_full[63:0];
      t3_r    <= t3_full[63:0];
      w1p5b_r <= w1p5_r;
      w1p2b_r <= w1p2_r;
      w2_r    <= w2_nxt;
      w1b_r   <= w1b_nxt;
      prod_r  <= prod_full[63:0];
      n0_r    <= n0_nxt;
      d_r     <= d_nxt;
      num_r   <= num_full[63:0];
      // stage 6: magnitudes for the unsigned divider
      ma_r    <= num_r[63] ? (64'd0 - num_r) : num_r;
      mb_r    <= d_r[63] ? (64'd0 - d_r) : d_r;
      neg_r   <= num_r[63] ^ d_r[63];
      inv_r   <= (d_r == 64'd0);
    end
  end

  assign valid   = v_r[5];
  assign ma      = ma_r;
  assign mb      = mb_r;
  assign neg     = neg_r;
  assign invalid = inv_r;
  assign temp_o  = tp_r[5];

endmodule

>>> rtl/psc_hum.sv
// ----------------------------------------------------------------------------
// psc_hum
// Six-stage humidity pipeline, 32-bit wrapping arithmetic with final clamp.
// ----------------------------------------------------------------------------
module psc_hum import psc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        fine,
  input  logic [RAW_H_W-1:0] raw_h,
  input  coeff_t             coeff,
  output logic [HUM_W-1:0]   hum
);

  logic [31:0] x, h2x, h4x, h5x, h6x, ha_pre, f1, f2, hb, s, t, x3, xc;
  logic [31:0] m5_r, mx6_r, mx3_r, ha_r, ha2_r, hbm_r, m2_r, x2_r, x2b_r, ss_r;
  logic [RAW_H_W-1:0] rh_r;
  logic [HUM_W-1:0]   hum_r;

  assign h2x = 32'($signed(coeff.h2));
  assign h4x = 32'($signed(coeff.h4));
  assign h5x = 32'($signed(coeff.h5));
  assign h6x = 32'($signed(coeff.h6));

  assign x = fine - 32'(HUM_FINE_OFS);

  assign ha_pre = (32'(rh_r) << 14) - (h4x << 20) - m5_r + 32'(HUM_RND);
  assign f1     = 32'($signed(mx6_r) >>> 10);
  assign f2     = 32'($signed(mx3_r) >>> 11) + 32'(HUM_K);

  assign hb = 32'($signed(m2_r + 32'(HUM_RND2)) >>> 14);
  assign s  = 32'($signed(x2_r) >>> 15);

  assign t  = 32'($signed(ss_r) >>> 7) * 32'(coeff.h1);
  assign x3 = x2b_r - 32'($signed(t) >>> 4);

  // clamp below at zero and above at full scale
  always_comb begin
    if (x3[31]) begin
      xc = 32'd0;
    end else if (x3 > 32'(HUM_MAX)) begin
      xc = 32'(HUM_MAX);
    end else begin
      xc = x3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rh_r  <= raw_h;
      m5_r  <= h5x * x;
      mx6_r <= x * h6x;
      mx3_r <= x * 32'(coeff.h3);
      ha_r  <= 32'($signed(ha_pre) >>> 15);
      hbm_r <= f1 * f2;
      ha2_r <= ha_r;
      m2_r  <= (32'($signed(hbm_r) >>> 10) + 32'(HUM_ADD)) * h2x;
      x2_r  <= ha2_r * hb;
      ss_r  <= s * s;
      x2b_r <= x2_r;
      hum_r <= coeff.has_hum ? xc[28:12] : '0;
    end
  end

  assign hum = hum_r;

endmodule

>>> rtl/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module psc_div import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  ma,
  input  logic [DIV_W-1:0]  mb,
  input  logic              neg_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid,
  output logic [DIV_W-1:0]  quo,
  output logic              neg_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              v_r    [0:DIV_W-1];
  logic [DIV_W-1:0]  rem_r  [0:DIV_W-1];
  logic [DIV_W-1:0]  dq_r   [0:DIV_W-1];
  logic [DIV_W-1:0]  mb_r   [0:DIV_W-1];
  logic              neg_r  [0:DIV_W-1];
  logic [SIDE_W-1:0] side_r [0:DIV_W-1];

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic              v_in, neg_in, ge;
    logic [DIV_W-1:0]  rem_in, dq_in, mb_in;
    logic [SIDE_W-1:0] side_in;
    logic [DIV_W:0]    sh, diff;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign dq_in   = ma;
      assign mb_in   = mb;
      assign neg_in  = neg_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign dq_in   = dq_r[i-1];
      assign mb_in   = mb_r[i-1];
      assign neg_in  = neg_r[i-1];
      assign side_in = side_r[i-1];
    end

    // shift in the next dividend bit, subtract when the divisor fits
    assign sh   = {rem_in, dq_in[DIV_W-1]};
    assign diff = sh - {1'b0, mb_in};
    assign ge   = (sh >= {1'b0, mb_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
        dq_r[i]   <= {dq_in[DIV_W-2:0], ge};
        mb_r[i]   <= mb_in;
        neg_r[i]  <= neg_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign valid  = v_r[DIV_W-1];
  assign quo    = dq_r[DIV_W-1];
  assign neg_o  = neg_r[DIV_W-1];
  assign side_o = side_r[DIV_W-1];

endmodule

>>> rtl/psc_pback.sv
// ----------------------------------------------------------------------------
// psc_pback
// Five-stage pressure back end: quotient sign, correction terms, output.
// ----------------------------------------------------------------------------
module psc_pback import psc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  quo,
  input  logic              neg,
  input  logic [SIDE_W-1:0] side_i,
  input  coeff_t            coeff,
  output logic              valid,
  output logic [31:0]       temperature,
  output logic [31:0]       pressure,
  output logic              pressure_invalid,
  output logic [HUM_W-1:0]  humidity
);

  logic              v_r    [0:4];
  logic [SIDE_W-1:0] side_r [0:3];

  logic        [63:0] p0_r, p1_r, p2_r, p3_r, q_r, pq_r, pp8_r, ll_r, prodq_r;
  logic        [63:0] w2v_r, w2v3_r;
  logic        [31:0] lh_r, hl_r;
  logic        [31:0] temp_r, press_r;
  logic               inv_r;
  logic [HUM_W-1:0]   hum_r;

  logic        [63:0] q, ll_nxt, prodq_nxt, w1v, sum, pr;
  logic        [31:0] lh_nxt, hl_nxt;
  logic signed [79:0] pq_full, pp8_full;
  logic               side_inv;

  assign q        = 64'($signed(p0_r) >>> 13);
  assign pq_full  = $signed(q) * $signed(coeff.p9);
  assign pp8_full = $signed(p0_r) * $signed(coeff.p8);

  // low 64 bits of pq * q from 32-bit partial products
  assign ll_nxt    = pq_r[31:0] * q_r[31:0];
  assign lh_nxt    = pq_r[31:0] * q_r[63:32];
  assign hl_nxt    = pq_r[63:32] * q_r[31:0];
  assign prodq_nxt = ll_r + {lh_r + hl_r, 32'd0};

  assign w1v = 64'($signed(prodq_r) >>> 25);
  assign sum = p3_r + w1v + w2v3_r;
  assign pr  = 64'($signed(sum) >>> 8) + (64'($signed(coeff.p7)) << 4);

  assign side_inv = side_r[3][SIDE_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < 5; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int i = 1; i < 4; i++) side_r[i] <= side_r[i-1];
      p0_r    <= neg ? (64'd0 - quo) : quo;
      q_r     <= q;
      pq_r    <= pq_full[63:0];
      pp8_r   <= pp8_full[63:0];
      p1_r    <= p0_r;
      ll_r    <= ll_nxt;
      lh_r    <= lh_nxt;
      hl_r    <= hl_nxt;
      w2v_r   <= 64'($signed(pp8_r) >>> 19);
      p2_r    <= p1_r;
      prodq_r <= prodq_nxt;
      w2v3_r  <= w2v_r;
      p3_r    <= p2_r;
      temp_r  <= side_r[3][31:0];
      hum_r   <= side_r[3][32 +: HUM_W];
      inv_r   <= side_inv;
      press_r <= side_inv ? 32'd0 : pr[31:0];
    end
  end

  assign valid            = v_r[4];
  assign temperature      = temp_r;
  assign pressure         = press_r;
  assign pressure_invalid = inv_r;
  assign humidity         = hum_r;

endmodule
